[rtl/core/hlsa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlsa_pkg
// Shared types and codes for the hole list segment allocator.
// ----------------------------------------------------------------------------
package hlsa_pkg;

    localparam int MAX_HOLES_DEF = 64;
    localparam int ADDR_BITS_DEF = 20;

    localparam logic [1:0] MODE_INIT    = 2'd0;
    localparam logic [1:0] MODE_ALLOC   = 2'd1;
    localparam logic [1:0] MODE_RELEASE = 2'd2;
    localparam logic [1:0] MODE_NOP     = 2'd3;

    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;
    localparam logic [1:0] FIT_SPARE = 2'd3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_COMPACT   = 3'd1;
    localparam logic [2:0] ST_NO_MEM    = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_BAD_INDEX = 3'd4;

    localparam logic CFG_FIT_POLICY  = 1'b0;
    localparam logic CFG_MEMORY_SIZE = 1'b1;

    typedef struct packed {
        logic [1:0]  mode;
        logic [20:0] request_size;
        logic [5:0]  entry_index;
    } hlsa_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [19:0] granted_base;
        logic [5:0]  granted_index;
        logic [20:0] free_total;
    } hlsa_out_t;

endpackage

[rtl/core/hole_list_segment_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hole_list_segment_allocator
// Address-ordered hole table with first, best and worst fit allocation.
// ----------------------------------------------------------------------------
// A request enters on in_valid/in_stall and one result leaves on
// out_valid/out_stall. Configuration (fit_policy index 0, memory_size
// index 1) is written through cfg_we/cfg_index/cfg_data; the user must
// write it only while idle, as the block itself does not enforce this.
// The table lives in a single-port-write, registered-read memory that a
// small sequencer walks one entry at a time, so in_stall stays high for
// the whole of a request. An allocation scans every hole, then on a split
// shifts the entries after the chosen one up to make room for the rest.
// A release reads the entry and its neighbours, writes the freed hole
// merged with any free neighbour, and on a merge shifts later entries down.
// The free byte total is kept in a register and updated per request.
// Reset empties the table (hole_count zero, no clearing pass) and sets
// fit_policy to first fit and memory_size to 4096. If the receiver stalls,
// the finished result is held and the sequencer waits before going idle.
module hole_list_segment_allocator
    import hlsa_pkg::*;
#(
    parameter int MAX_HOLES = MAX_HOLES_DEF,
    parameter int ADDR_BITS = ADDR_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  hlsa_in_t    in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output hlsa_out_t   out_data,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [20:0] cfg_data
);

    localparam int IW   = $clog2(MAX_HOLES);
    localparam int CW   = $clog2(MAX_HOLES + 1);
    localparam int SZW  = (ADDR_BITS + 1 > 21) ? ADDR_BITS + 1 : 21;
    localparam int CMPW = (CW > 6) ? CW : 6;
    localparam logic [SZW-1:0] CAP = SZW'(1) << ADDR_BITS;

    typedef struct packed {
        logic [ADDR_BITS-1:0] base;
        logic [SZW-1:0]       size;
        logic                 free;
    } hole_t;

    typedef enum logic [3:0] {
        S_IDLE, S_SCAN_RD, S_SCAN_CHK, S_SCAN_END, S_INS_RD, S_INS_WR, S_INS_FIN,
        S_R0, S_R1, S_R2, S_R3, S_R4, S_REM_RD, S_REM_WR, S_DONE
    } state_t;

    hole_t tbl [MAX_HOLES];
    hole_t rd_q;

    state_t         state_reg, state_next;
    logic [CW-1:0]  count_reg, count_next;
    logic [CW-1:0]  j_reg, j_next;
    logic [CW-1:0]  newcnt_reg, newcnt_next;
    logic [IW-1:0]  p_reg, p_next;
    logic [1:0]     k_reg, k_next;
    logic           found_reg, found_next;
    logic           hn_reg, hn_next;
    hole_t          best_reg, best_next;
    hole_t          prev_reg, prev_next;
    hole_t          cur_reg, cur_next;
    hole_t          nxt_reg, nxt_next;
    logic [SZW-1:0] free_sum_reg, free_sum_next;
    hlsa_in_t       req_reg, req_next;
    logic [2:0]     status_reg, status_next;
    logic [ADDR_BITS-1:0] gbase_reg, gbase_next;
    logic [IW-1:0]  gidx_reg, gidx_next;
    logic           out_valid_reg, out_valid_next;
    hlsa_out_t      out_reg, out_next;
    logic [1:0]     policy_reg;
    logic [20:0]    memsize_reg;

    logic           mem_we;
    logic [IW-1:0]  mem_waddr, mem_raddr;
    hole_t          mem_wdata;

    logic [SZW-1:0] req_sz;
    logic [SZW-1:0] init_sz;
    logic           fits, better, lf, rf;
    logic [SZW-1:0] merged_sz;

    assign req_sz  = SZW'(req_reg.request_size);
    assign init_sz = (SZW'(memsize_reg) > CAP) ? CAP : SZW'(memsize_reg);

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        j_next        = j_reg;
        newcnt_next   = newcnt_reg;
        p_next        = p_reg;
        k_next        = k_reg;
        found_next    = found_reg;
        hn_next       = hn_reg;
        best_next     = best_reg;
        prev_next     = prev_reg;
        cur_next      = cur_reg;
        nxt_next      = nxt_reg;
        free_sum_next = free_sum_reg;
        req_next      = req_reg;
        status_next   = status_reg;
        gbase_next    = gbase_reg;
        gidx_next     = gidx_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_next      = out_reg;
        mem_we        = 1'b0;
        mem_waddr     = '0;
        mem_wdata     = '0;
        mem_raddr     = '0;
        fits          = rd_q.free && (rd_q.size >= req_sz);
        better        = !found_reg
                        || (policy_reg == FIT_BEST && rd_q.size < best_reg.size)
                        || (policy_reg == FIT_WORST && rd_q.size > best_reg.size);
        lf            = (req_reg.entry_index != 6'd0) && prev_reg.free;
        rf            = hn_reg && nxt_reg.free;
        merged_sz     = (lf ? prev_reg.size : '0) + cur_reg.size
                        + (rf ? nxt_reg.size : '0);

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    req_next    = in_data;
                    status_next = ST_OK;
                    gbase_next  = '0;
                    gidx_next   = '0;
                    j_next      = '0;
                    found_next  = 1'b0;
                    case (in_data.mode)
                        MODE_INIT:
                        begin
                            mem_we        = 1'b1;
                            mem_waddr     = '0;
                            mem_wdata     = '{base: '0, size: init_sz, free: 1'b1};
                            count_next    = CW'(1);
                            free_sum_next = init_sz;
                            state_next    = S_DONE;
                        end
                        MODE_ALLOC:
                        begin
                            if (in_data.request_size == 21'd0)
                            begin
                                status_next = ST_NO_MEM;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                state_next = S_SCAN_RD;
                            end
                        end
                        MODE_RELEASE: state_next = S_R0;
                        default:      state_next = S_DONE;
                    endcase
                end
            end
            S_SCAN_RD:
            begin
                mem_raddr = IW'(j_reg);
                state_next = (j_reg >= count_reg) ? S_SCAN_END : S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                // First fit keeps the earliest hit; the others keep the lowest
                // position on a tie because only a strict improvement replaces.
                if (fits && better)
                begin
                    found_next = 1'b1;
                    best_next  = rd_q;
                    p_next     = IW'(j_reg);
                end
                j_next     = j_reg + CW'(1);
                state_next = S_SCAN_RD;
            end
            S_SCAN_END:
            begin
                state_next = S_DONE;
                if (!found_reg)
                begin
                    status_next = (free_sum_reg >= req_sz) ? ST_COMPACT : ST_NO_MEM;
                end
                else if (best_reg.size > req_sz && count_reg >= CW'(MAX_HOLES))
                begin
                    status_next = ST_FULL;
                end
                else
                begin
                    gbase_next    = best_reg.base;
                    gidx_next     = p_reg;
                    free_sum_next = free_sum_reg - req_sz;
                    if (best_reg.size > req_sz)
                    begin
                        j_next     = count_reg - CW'(1);
                        state_next = S_INS_RD;
                    end
                    else
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = p_reg;
                        mem_wdata = '{base: best_reg.base, size: best_reg.size, free: 1'b0};
                    end
                end
            end
            S_INS_RD:
            begin
                if (j_reg > CW'(p_reg))
                begin
                    mem_raddr  = IW'(j_reg);
                    state_next = S_INS_WR;
                end
                else
                begin
                    mem_we     = 1'b1;
                    mem_waddr  = p_reg + IW'(1);
                    mem_wdata  = '{base: best_reg.base + ADDR_BITS'(req_sz),
                                   size: best_reg.size - req_sz, free: 1'b1};
                    state_next = S_INS_FIN;
                end
            end
            S_INS_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = IW'(j_reg + CW'(1));
                mem_wdata  = rd_q;
                j_next     = j_reg - CW'(1);
                state_next = S_INS_RD;
            end
            S_INS_FIN:
            begin
                mem_we     = 1'b1;
                mem_waddr  = p_reg;
                mem_wdata  = '{base: best_reg.base, size: req_sz, free: 1'b0};
                count_next = count_reg + CW'(1);
                state_next = S_DONE;
            end
            S_R0:
            begin
                if (CMPW'(req_reg.entry_index) >= CMPW'(count_reg))
                begin
                    status_next = ST_BAD_INDEX;
                    state_next  = S_DONE;
                end
                else if (req_reg.entry_index != 6'd0)
                begin
                    mem_raddr  = IW'(req_reg.entry_index) - IW'(1);
                    state_next = S_R1;
                end
                else
                begin
                    prev_next  = '0;
                    mem_raddr  = IW'(req_reg.entry_index);
                    state_next = S_R2;
                end
            end
            S_R1:
            begin
                prev_next  = rd_q;
                mem_raddr  = IW'(req_reg.entry_index);
                state_next = S_R2;
            end
            S_R2:
            begin
                cur_next = rd_q;
                hn_next  = CMPW'(req_reg.entry_index) + CMPW'(1) < CMPW'(count_reg);
                if (CMPW'(req_reg.entry_index) + CMPW'(1) < CMPW'(count_reg))
                begin
                    mem_raddr  = IW'(req_reg.entry_index) + IW'(1);
                    state_next = S_R3;
                end
                else
                begin
                    state_next = S_R4;
                end
            end
            S_R3:
            begin
                nxt_next   = rd_q;
                state_next = S_R4;
            end
            S_R4:
            begin
                p_next     = lf ? IW'(req_reg.entry_index) - IW'(1)
                                : IW'(req_reg.entry_index);
                mem_we     = 1'b1;
                mem_waddr  = p_next;
                mem_wdata  = '{base: lf ? prev_reg.base : cur_reg.base,
                               size: merged_sz, free: 1'b1};
                gbase_next = mem_wdata.base;
                gidx_next  = p_next;
                if (!cur_reg.free)
                begin
                    free_sum_next = free_sum_reg + cur_reg.size;
                end
                k_next      = {1'b0, lf} + {1'b0, rf};
                newcnt_next = count_reg - CW'(k_next);
                j_next      = CW'(p_next) + CW'(1);
                state_next  = (lf || rf) ? S_REM_RD : S_DONE;
            end
            S_REM_RD:
            begin
                if (j_reg >= newcnt_reg)
                begin
                    count_next = newcnt_reg;
                    state_next = S_DONE;
                end
                else
                begin
                    mem_raddr  = IW'(j_reg + CW'(k_reg));
                    state_next = S_REM_WR;
                end
            end
            S_REM_WR:
            begin
                mem_we     = 1'b1;
                mem_waddr  = IW'(j_reg);
                mem_wdata  = rd_q;
                j_next     = j_reg + CW'(1);
                state_next = S_REM_RD;
            end
            S_DONE:
            begin
                if (!(out_valid_reg && out_stall))
                begin
                    out_valid_next         = 1'b1;
                    out_next.status        = status_reg;
                    out_next.granted_base  = 20'(gbase_reg);
                    out_next.granted_index = 6'(gidx_reg);
                    out_next.free_total    = 21'(free_sum_reg);
                    state_next             = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            free_sum_reg  <= '0;
            out_valid_reg <= 1'b0;
            policy_reg    <= FIT_FIRST;
            memsize_reg   <= 21'd4096;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            free_sum_reg  <= free_sum_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_FIT_POLICY:  policy_reg  <= cfg_data[1:0];
                    CFG_MEMORY_SIZE: memsize_reg <= cfg_data;
                    default:         policy_reg  <= policy_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        j_reg      <= j_next;
        newcnt_reg <= newcnt_next;
        p_reg      <= p_next;
        k_reg      <= k_next;
        found_reg  <= found_next;
        hn_reg     <= hn_next;
        best_reg   <= best_next;
        prev_reg   <= prev_next;
        cur_reg    <= cur_next;
        nxt_reg    <= nxt_next;
        req_reg    <= req_next;
        status_reg <= status_next;
        gbase_reg  <= gbase_next;
        gidx_reg   <= gidx_next;
        out_reg    <= out_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            tbl[mem_waddr] <= mem_wdata;
        end
        rd_q <= tbl[mem_raddr];
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_HOLES))
        else $error("hole count exceeds table depth");

    a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
        free_sum_reg <= CAP)
        else $error("free byte total exceeds managed space");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside the done step");

endmodule

[bench/hlsa_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hlsa_checker
// Watches the request, result and register ports of the hole allocator,
// keeps its own copy of the hole table, and compares every result in order.
// ----------------------------------------------------------------------------
module hlsa_checker
    import hlsa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  hlsa_in_t    in_data,
    input  logic        out_valid,
    input  logic        out_stall,
    input  hlsa_out_t   out_data,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [20:0] cfg_data,
    output int          errors,
    output int          pending
);

    localparam int TABLE_DEPTH = 64;
    localparam logic [21:0] SPACE_CAP = 22'd1 << 20;

    logic [21:0] seg_base [TABLE_DEPTH];
    logic [21:0] seg_size [TABLE_DEPTH];
    logic        seg_free [TABLE_DEPTH];
    int          seg_count;
    logic [1:0]  policy;
    logic [20:0] space_size;
    hlsa_out_t   expected_results [$];

    function automatic logic [21:0] free_bytes();
        logic [21:0] total;
        total = '0;
        for (int i = 0; i < seg_count; i++)
            if (seg_free[i])
                total += seg_size[i];
        return total;
    endfunction

    // Returns seg_count when no free hole is large enough.
    function automatic int choose_hole(input logic [21:0] req);
        int pick;
        pick = seg_count;
        for (int i = 0; i < seg_count; i++)
        begin
            if (seg_free[i] && seg_size[i] >= req)
            begin
                if (policy == FIT_BEST)
                begin
                    if (pick == seg_count || seg_size[i] < seg_size[pick])
                        pick = i;
                end
                else if (policy == FIT_WORST)
                begin
                    if (pick == seg_count || seg_size[i] > seg_size[pick])
                        pick = i;
                end
                else
                begin
                    return i;
                end
            end
        end
        return pick;
    endfunction

    task automatic drop_entry(input int pos);
        for (int i = pos; i + 1 < seg_count; i++)
        begin
            seg_base[i] = seg_base[i + 1];
            seg_size[i] = seg_size[i + 1];
            seg_free[i] = seg_free[i + 1];
        end
        seg_count--;
    endtask

    task automatic serve_request(input hlsa_in_t r, output hlsa_out_t res);
        logic [21:0] req;
        logic [21:0] total_after;
        int p;
        int cur;
        res = '0;
        req = {1'b0, r.request_size};
        if (r.mode == MODE_INIT)
        begin
            seg_base[0] = '0;
            seg_size[0] = ({1'b0, space_size} > SPACE_CAP) ? SPACE_CAP : {1'b0, space_size};
            seg_free[0] = 1'b1;
            seg_count = 1;
        end
        else if (r.mode == MODE_ALLOC)
        begin
            if (req == 0)
            begin
                res.status = ST_NO_MEM;
            end
            else
            begin
                p = choose_hole(req);
                if (p >= seg_count)
                begin
                    res.status = (free_bytes() >= req) ? ST_COMPACT : ST_NO_MEM;
                end
                else if (seg_size[p] > req && seg_count >= TABLE_DEPTH)
                begin
                    res.status = ST_FULL;
                end
                else
                begin
                    if (seg_size[p] > req)
                    begin
                        for (int i = seg_count; i > p + 1; i--)
                        begin
                            seg_base[i] = seg_base[i - 1];
                            seg_size[i] = seg_size[i - 1];
                            seg_free[i] = seg_free[i - 1];
                        end
                        seg_base[p + 1] = seg_base[p] + req;
                        seg_size[p + 1] = seg_size[p] - req;
                        seg_free[p + 1] = 1'b1;
                        seg_count++;
                        seg_size[p] = req;
                    end
                    seg_free[p] = 1'b0;
                    res.granted_base = seg_base[p][19:0];
                    res.granted_index = p[5:0];
                end
            end
        end
        else if (r.mode == MODE_RELEASE)
        begin
            if (int'(r.entry_index) >= seg_count)
            begin
                res.status = ST_BAD_INDEX;
            end
            else
            begin
                cur = int'(r.entry_index);
                seg_free[cur] = 1'b1;
                if (cur > 0 && seg_free[cur - 1])
                begin
                    seg_size[cur - 1] += seg_size[cur];
                    drop_entry(cur);
                    cur--;
                end
                if (cur + 1 < seg_count && seg_free[cur + 1])
                begin
                    seg_size[cur] += seg_size[cur + 1];
                    drop_entry(cur + 1);
                end
                res.granted_base = seg_base[cur][19:0];
                res.granted_index = cur[5:0];
            end
        end
        total_after = free_bytes();
        res.free_total = total_after[20:0];
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        hlsa_out_t want;
        hlsa_out_t got;
        if (!rst_n)
        begin
            seg_count = 0;
            policy = FIT_FIRST;
            space_size = 21'd4096;
            errors = 0;
            expected_results.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_FIT_POLICY)
                    policy = cfg_data[1:0];
                else
                    space_size = cfg_data;
            end
            if (in_valid && !in_stall)
            begin
                serve_request(in_data, want);
                expected_results.push_back(want);
            end
            if (out_valid && !out_stall)
            begin
                got = out_data;
                if (expected_results.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: result with no request pending: %p", $realtime, got);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got !== want)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("%0t: mismatch expected %p actual %p",
                                     $realtime, want, got);
                    end
                end
            end
        end
        pending = expected_results.size();
    end

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Directed and random requests for the hole list segment allocator across
// fit policies and memory sizes, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module tb
    import hlsa_pkg::*;
();

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 300;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    hlsa_in_t    in_data;
    logic        out_valid;
    logic        out_stall;
    hlsa_out_t   out_data;
    logic        cfg_we;
    logic        cfg_index;
    logic [20:0] cfg_data;
    int          errors;
    int          pending;
    logic        calm;
    logic        hold_go;
    int          stall_left;
    int          idle_cycles;

    hole_list_segment_allocator dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    hlsa_checker chk (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .pending(pending)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (calm)
            return 0;
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(30, 120);
    endfunction

    // Result-side stall: random bursts, plus one long hold-off on request.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left <= 0;
        end
        else if (hold_go)
        begin
            out_stall <= 1'b1;
            stall_left <= 400;
        end
        else if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else
        begin
            stall_left <= gap_length();
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send_request(input logic [1:0] mode, input logic [20:0] size,
                                input logic [5:0] index);
        int gap;
        in_valid <= 1'b1;
        in_data <= '{mode: mode, request_size: size, entry_index: index};
        do
            @(posedge clk);
        while (in_stall);
        gap = gap_length();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic write_register(input logic index, input logic [20:0] value);
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_request(input logic [20:0] space);
        int r;
        logic [20:0] size;
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            case ($urandom_range(0, 9))
                0:       size = 21'($urandom_range(0, 2097151));
                1:       size = 21'($urandom_range(1, (space > 4) ? space : 4));
                2, 3:    size = 21'($urandom_range(1, (space / 8 > 1) ? space / 8 : 1));
                default: size = 21'($urandom_range(1, 64));
            endcase
            send_request(MODE_ALLOC, size, 6'($urandom_range(0, 63)));
        end
        else if (r < 96)
        begin
            send_request(MODE_RELEASE, 21'($urandom_range(0, 2097151)),
                         ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                                     : 6'($urandom_range(0, 20)));
        end
        else if (r < 98)
        begin
            send_request(MODE_INIT, 21'($urandom_range(0, 2097151)),
                         6'($urandom_range(0, 63)));
        end
        else
        begin
            send_request(MODE_NOP, 21'($urandom_range(0, 2097151)),
                         6'($urandom_range(0, 63)));
        end
    endtask

    initial
    begin
        logic [1:0]  policies [9] = '{FIT_FIRST, FIT_BEST, FIT_WORST, FIT_SPARE, FIT_BEST,
                                     FIT_WORST, FIT_FIRST, FIT_BEST, FIT_WORST};
        logic [20:0] spaces [9] = '{21'd4096, 21'd4096, 21'd1000, 21'd1048576,
                                   21'd2097151, 21'd1, 21'd0, 21'd300, 21'd65536};
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_index = CFG_FIT_POLICY;
        cfg_data = '0;
        calm = 1'b0;
        hold_go = 1'b0;
        idle_cycles = 0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty table first, then the corners of each operation.
        send_request(MODE_ALLOC, 21'd16, 6'd0);
        send_request(MODE_RELEASE, 21'd0, 6'd0);
        send_request(MODE_NOP, 21'h1FFFFF, 6'h3F);
        send_request(MODE_INIT, 21'd0, 6'd0);
        send_request(MODE_ALLOC, 21'd0, 6'd0);
        send_request(MODE_ALLOC, 21'h1FFFFF, 6'd0);
        send_request(MODE_ALLOC, 21'd100, 6'd0);
        send_request(MODE_ALLOC, 21'd200, 6'd0);
        send_request(MODE_ALLOC, 21'd300, 6'd0);
        send_request(MODE_RELEASE, 21'd0, 6'd1);
        send_request(MODE_RELEASE, 21'd0, 6'd1);
        send_request(MODE_ALLOC, 21'd3600, 6'd0);
        send_request(MODE_ALLOC, 21'd250, 6'd0);
        send_request(MODE_RELEASE, 21'd0, 6'h3F);
        send_request(MODE_RELEASE, 21'd0, 6'd0);
        send_request(MODE_ALLOC, 21'd3796, 6'd0);
        send_request(MODE_RELEASE, 21'd0, 6'd2);
        send_request(MODE_ALLOC, 21'd96, 6'd0);
        send_request(MODE_RELEASE, 21'd0, 6'd0);
        send_request(MODE_RELEASE, 21'd0, 6'd1);

        for (int ph = 0; ph < 9; ph++)
        begin
            write_register(CFG_FIT_POLICY, {19'd0, policies[ph]});
            write_register(CFG_MEMORY_SIZE, spaces[ph]);
            calm = (ph == 3 || ph == 7);
            send_request(MODE_INIT, 21'($urandom_range(0, 2097151)),
                         6'($urandom_range(0, 63)));
            if (ph == 1)
            begin
                hold_go <= 1'b1;
                @(posedge clk);
                hold_go <= 1'b0;
            end
            // Small sizes fill the table in one long run of allocations in phase 0.
            for (int n = 0; n < 200; n++)
            begin
                if (ph == 0 && n < 70)
                    send_request(MODE_ALLOC, 21'($urandom_range(1, 40)),
                                 6'($urandom_range(0, 63)));
                else
                    random_request(spaces[ph]);
            end
        end

        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
